FILE: rtl/core/spectrum_band_peak_falloff_macros.svh
// ----------------------------------------------------------------------------
// spectrum_band_peak_falloff assertion macros
// concurrent assertion wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAND_PEAK_FALLOFF_MACROS_SVH
`define SPECTRUM_BAND_PEAK_FALLOFF_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SBPF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sbpf assertion failed");
// next-cycle implication
`define SBPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sbpf assertion failed");
`else
`define SBPF_ASSERT_NOW(label, ante, cons)
`define SBPF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/sbpf_pkg.sv
// ----------------------------------------------------------------------------
// sbpf_pkg
// shared constants, types and helpers of the band peak falloff block
// ----------------------------------------------------------------------------
package sbpf_pkg;

    localparam int BANDS  = 5;
    localparam int MAG_W  = 24;
    localparam int CNT_W  = 16;
    localparam int IDX_W  = 5;
    localparam int KW     = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int SLOT_W = $clog2(BANDS + 3) + 1;

    localparam logic [CNT_W-1:0] BIN_COUNT_RST  = 16'd256;
    localparam logic [MAG_W-1:0] DECAY_STEP_RST = 24'd128;
    localparam logic signed [SLOT_W-1:0] SLOT_INIT = SLOT_W'(-2);

    // band size divisor, done as reciprocal multiply (exact for 16-bit counts)
    localparam int DIV    = BANDS + 1;
    localparam int DIV_SH = CNT_W + $clog2(DIV);
    localparam logic [DIV_SH-1:0] DIV_RCP =
        DIV_SH'(((64'd1 << DIV_SH) + 64'(DIV) - 64'd1) / 64'(DIV));

    typedef enum logic {
        REG_BIN_COUNT  = 1'b0,
        REG_DECAY_STEP = 1'b1
    } reg_index_t;

    typedef enum logic {
        BACK_IDLE = 1'b0,
        BACK_RUN  = 1'b1
    } back_state_t;

    typedef logic [BANDS-1:0][MAG_W-1:0] band_vec_t;

    typedef struct packed {
        logic      valid;
        band_vec_t maxima;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [CNT_W-1:0] band_chg(input logic [CNT_W-1:0] count);
        logic [DIV_SH+CNT_W-1:0] prod;
        prod = (DIV_SH + CNT_W)'(count) * (DIV_SH + CNT_W)'(DIV_RCP);
        return prod[DIV_SH +: CNT_W];
    endfunction

endpackage

FILE: rtl/core/spectrum_band_peak_falloff.sv
// ----------------------------------------------------------------------------
// spectrum_band_peak_falloff
// band peak hold with decay over one frame of spectrum bins
// ----------------------------------------------------------------------------
//  channel  | dir | payload                             | transfer when
//  s_       | in  | magnitude                           | s_tvalid & s_tready
//  m_       | out | band_index, bar_level, last (tlast) | m_tvalid & m_tready
//  apb      | in  | bin_count @0x0, decay_step @0x4     | psel & penable & pwrite
//
//  one bin per cycle while the frame queue (two frames) has room
//  each frame end yields BANDS bars, one per cycle unless m_tready stalls them
//  after a frame's last bin, bar 0 passes queue, frame and output registers
//  a stalled result channel backs up the queue, then holds s_tready low
//  synchronous reset, no clearing pass
// ----------------------------------------------------------------------------
`include "spectrum_band_peak_falloff_macros.svh"

module spectrum_band_peak_falloff (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] magnitude
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [4:0] band_index, [28:5] bar_level, rest zero
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sbpf_pkg::*;

    logic [CNT_W-1:0] bin_count_reg;
    logic [CNT_W-1:0] chg_reg;
    logic [MAG_W-1:0] decay_step_reg;
    logic             cfg_wr;
    reg_index_t       cfg_idx;

    push_t            push;
    q_status_t        q_stat;
    band_vec_t        head;
    logic             pop;
    logic [IDX_W-1:0] out_index;
    logic [MAG_W-1:0] out_level;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_index_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_count_reg  <= BIN_COUNT_RST;
            chg_reg        <= band_chg(BIN_COUNT_RST);
            decay_step_reg <= DECAY_STEP_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BIN_COUNT: begin
                    bin_count_reg <= pwdata[CNT_W-1:0];
                    // band size follows the raw count, zero acts as one
                    chg_reg       <= band_chg((pwdata[CNT_W-1:0] == '0) ?
                                              CNT_W'(1) : pwdata[CNT_W-1:0]);
                end
                REG_DECAY_STEP: decay_step_reg <= pwdata[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_BIN_COUNT:  prdata = {16'd0, bin_count_reg};
            REG_DECAY_STEP: prdata = {8'd0, decay_step_reg};
            default:        prdata = '0;
        endcase
    end

    sbpf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mag    (s_tdata),
        .bin_count (bin_count_reg),
        .chg       (chg_reg),
        .q_stat    (q_stat),
        .push      (push)
    );

    sbpf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .q_stat  (q_stat)
    );

    sbpf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .head       (head),
        .pop        (pop),
        .decay_step (decay_step_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_index  (out_index),
        .out_level  (out_level),
        .out_last   (m_tlast)
    );

    assign m_tdata = {3'd0, out_level, out_index};

    `SBPF_ASSERT_NOW(a_no_push_when_full, push.valid, !q_stat.full)
    `SBPF_ASSERT_NOW(a_last_on_top_band, m_tvalid && m_tlast, m_tdata[4:0] == IDX_W'(BANDS - 1))
    `SBPF_ASSERT_NEXT(a_bars_back_to_back, m_tvalid && m_tready && !m_tlast, m_tvalid)
    `SBPF_ASSERT_NEXT(a_band_steps_by_one, m_tvalid && m_tready && !m_tlast,
                      m_tdata[4:0] == 5'($past(m_tdata[4:0]) + 5'd1))

endmodule

FILE: rtl/core/sbpf_front.sv
// ----------------------------------------------------------------------------
// sbpf_front
// takes bins, tracks band maxima and pushes one frame of maxima at frame end
// ----------------------------------------------------------------------------
module sbpf_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sbpf_pkg::MAG_W-1:0]     in_mag,
    input  logic [sbpf_pkg::CNT_W-1:0]     bin_count,
    input  logic [sbpf_pkg::CNT_W-1:0]     chg,
    input  sbpf_pkg::q_status_t            q_stat,
    output sbpf_pkg::push_t                push
);
    import sbpf_pkg::*;

    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        bib_reg, bib_next;
    logic signed [SLOT_W-1:0] slot_reg, slot_next;
    logic [MAG_W-1:0]        rmax_reg, rmax_next;
    band_vec_t               bm_reg, bm_next;

    logic [CNT_W-1:0] count;
    logic [MAG_W-1:0] rm;
    logic             frame_end;
    logic             accept;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign count    = (bin_count == '0) ? CNT_W'(1) : bin_count;

    always_comb begin
        rm        = (in_mag > rmax_reg) ? in_mag : rmax_reg;
        bib_next  = bib_reg + CNT_W'(1);
        slot_next = slot_reg;
        bm_next   = bm_reg;
        if (bib_next > chg) begin
            bib_next = '0;
            if (slot_next < $signed(SLOT_W'(BANDS))) begin
                slot_next = slot_next + SLOT_W'(1);
            end
            for (int k = 0; k < BANDS; k++) begin
                if (slot_next == SLOT_W'(k)) begin
                    bm_next[k] = rm;
                end
            end
            rm = '0;
        end
        pos_next  = pos_reg + CNT_W'(1);
        frame_end = (pos_next == '0) || (pos_next >= count);
        // trailing partial band
        if (frame_end && (slot_next < $signed(SLOT_W'(BANDS - 1)))) begin
            slot_next = slot_next + SLOT_W'(1);
            for (int k = 0; k < BANDS; k++) begin
                if (slot_next == SLOT_W'(k)) begin
                    bm_next[k] = rm;
                end
            end
        end
        rmax_next   = rm;
        push.valid  = accept && frame_end;
        push.maxima = bm_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            bib_reg  <= '0;
            slot_reg <= SLOT_INIT;
            rmax_reg <= '0;
            bm_reg   <= '0;
        end else if (accept) begin
            if (frame_end) begin
                pos_reg  <= '0;
                bib_reg  <= '0;
                slot_reg <= SLOT_INIT;
                rmax_reg <= '0;
                bm_reg   <= '0;
            end else begin
                pos_reg  <= pos_next;
                bib_reg  <= bib_next;
                slot_reg <= slot_next;
                rmax_reg <= rmax_next;
                bm_reg   <= bm_next;
            end
        end
    end

endmodule

FILE: rtl/core/sbpf_queue.sv
// ----------------------------------------------------------------------------
// sbpf_queue
// two-entry queue of frame maxima between front and back
// ----------------------------------------------------------------------------
module sbpf_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sbpf_pkg::push_t       push,
    input  logic                  pop,
    output sbpf_pkg::band_vec_t   head,
    output sbpf_pkg::q_status_t   q_stat
);
    import sbpf_pkg::*;

    band_vec_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    always_comb begin
        wr_ptr_next  = wr_ptr_reg ^ push.valid;
        rd_ptr_next  = rd_ptr_reg ^ pop;
        fill_next    = fill_reg + 2'(push.valid) - 2'(pop);
        q_stat.full  = (fill_reg == 2'd2);
        q_stat.empty = (fill_reg == 2'd0);
        head         = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.maxima;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: rtl/core/sbpf_back.sv
// ----------------------------------------------------------------------------
// sbpf_back
// updates the persistent bars, one band per cycle unless stalled, emits them
// ----------------------------------------------------------------------------
module sbpf_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sbpf_pkg::q_status_t            q_stat,
    input  sbpf_pkg::band_vec_t            head,
    output logic                           pop,
    input  logic [sbpf_pkg::MAG_W-1:0]     decay_step,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sbpf_pkg::IDX_W-1:0]     out_index,
    output logic [sbpf_pkg::MAG_W-1:0]     out_level,
    output logic                           out_last
);
    import sbpf_pkg::*;

    back_state_t      state_reg, state_next;
    logic [KW-1:0]    k_reg, k_next;
    band_vec_t        frame_reg;
    logic [MAG_W-1:0] bar_reg [BANDS];
    logic             valid_reg, valid_next;
    logic [IDX_W-1:0] index_reg;
    logic [MAG_W-1:0] level_reg;
    logic             last_reg;

    logic             issue;
    logic             last_k;
    logic [MAG_W-1:0] cur_max, cur_bar, new_bar;

    always_comb begin
        cur_max = frame_reg[k_reg];
        cur_bar = bar_reg[k_reg];
        if (cur_max >= cur_bar) begin
            new_bar = cur_max;
        end else if (cur_bar > decay_step) begin
            new_bar = cur_bar - decay_step;
        end else begin
            new_bar = '0;
        end
        last_k     = (k_reg == KW'(BANDS - 1));
        issue      = 1'b0;
        pop        = 1'b0;
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            BACK_IDLE: begin
                if (!q_stat.empty) begin
                    pop        = 1'b1;
                    k_next     = '0;
                    state_next = BACK_RUN;
                end
            end
            BACK_RUN: begin
                issue = !valid_reg || out_ready;
                if (issue) begin
                    k_next = k_reg + KW'(1);
                    if (last_k) begin
                        state_next = BACK_IDLE;
                    end
                end
            end
            default: state_next = BACK_IDLE;
        endcase
        if (issue) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BACK_IDLE;
            k_reg     <= '0;
            valid_reg <= 1'b0;
            for (int k = 0; k < BANDS; k++) begin
                bar_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
            if (issue) begin
                bar_reg[k_reg] <= new_bar;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            frame_reg <= head;
        end
        if (issue) begin
            index_reg <= IDX_W'(k_reg);
            level_reg <= new_bar;
            last_reg  <= last_k;
        end
    end

    assign out_valid = valid_reg;
    assign out_index = index_reg;
    assign out_level = level_reg;
    assign out_last  = last_reg;

endmodule
